### hw/rtl/lc3_pkg.sv
// Shared types and constants for the LC-3 instruction core.
// Used by lc3_ctrl, lc3_dp and lc3_instruction_core_unit; depends on nothing.
package lc3_pkg;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] address;
    logic [15:0] data;
    logic [7:0]  key;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [15:0] pc_now;
    logic [7:0]  char_out;
    logic [15:0] data_out;
    logic [2:0]  flags;
    logic        stopped;
  } out_item_t;

  // Controller step codes, also the state codes of the controller.
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ISSUE = 4'd2;
  localparam logic [3:0] S_RDONE = 4'd3;
  localparam logic [3:0] S_DEC   = 4'd4;
  localparam logic [3:0] S_EXEC  = 4'd5;
  localparam logic [3:0] S_IND   = 4'd6;
  localparam logic [3:0] S_STI   = 4'd7;
  localparam logic [3:0] S_WB    = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  typedef struct packed {
    logic       load;
    logic [3:0] step;
  } cmd_t;

  typedef struct packed {
    logic       clear_done;
    logic [1:0] action;
    logic       halted;
    logic       need_ind;
    logic       need_sti;
    logic       need_wb;
  } stat_t;

  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_STEP    = 2'd2;
  localparam logic [1:0] ACT_RESTART = 2'd3;

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_CHAR    = 3'd1;
  localparam logic [2:0] EV_HALT    = 3'd2;
  localparam logic [2:0] EV_ILLEGAL = 3'd3;
  localparam logic [2:0] EV_STRING  = 3'd4;
  localparam logic [2:0] EV_STOPPED = 3'd5;

  localparam logic [3:0] OP_BR   = 4'h0;
  localparam logic [3:0] OP_ADD  = 4'h1;
  localparam logic [3:0] OP_LD   = 4'h2;
  localparam logic [3:0] OP_ST   = 4'h3;
  localparam logic [3:0] OP_JSR  = 4'h4;
  localparam logic [3:0] OP_AND  = 4'h5;
  localparam logic [3:0] OP_LDR  = 4'h6;
  localparam logic [3:0] OP_STR  = 4'h7;
  localparam logic [3:0] OP_NOT  = 4'h9;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_STI  = 4'hB;
  localparam logic [3:0] OP_JMP  = 4'hC;
  localparam logic [3:0] OP_LEA  = 4'hE;
  localparam logic [3:0] OP_TRAP = 4'hF;

  localparam logic [7:0] TV_GETC  = 8'h20;
  localparam logic [7:0] TV_OUT   = 8'h21;
  localparam logic [7:0] TV_PUTS  = 8'h22;
  localparam logic [7:0] TV_IN    = 8'h23;
  localparam logic [7:0] TV_PUTSP = 8'h24;
  localparam logic [7:0] TV_HALT  = 8'h25;

  localparam logic [15:0] START_PC_RESET = 16'h3000;
  localparam logic [2:0]  FLAG_P = 3'd1;
  localparam logic [2:0]  FLAG_Z = 3'd2;
  localparam logic [2:0]  FLAG_N = 3'd4;

  function automatic logic [2:0] flags_of(input logic [15:0] v);
    logic [2:0] f;
    if (v == 16'd0) begin
      f = FLAG_Z;
    end else if (v[15]) begin
      f = FLAG_N;
    end else begin
      f = FLAG_P;
    end
    return f;
  endfunction

endpackage

### hw/rtl/lc3_ctrl.sv
// Controller state machine of the LC-3 core: sequences memory clear, host
// actions and instruction steps. Depends on lc3_pkg.
module lc3_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  lc3_pkg::stat_t stat,
  output lc3_pkg::cmd_t  cmd
);

  logic [3:0] state;
  logic [3:0] state_next;

  always_comb begin
    state_next = state;
    case (state)
      lc3_pkg::S_CLEAR: begin
        if (stat.clear_done) state_next = lc3_pkg::S_IDLE;
      end
      lc3_pkg::S_IDLE: begin
        if (in_valid) state_next = lc3_pkg::S_ISSUE;
      end
      lc3_pkg::S_ISSUE: begin
        if (stat.action == lc3_pkg::ACT_READ) begin
          state_next = lc3_pkg::S_RDONE;
        end else if (stat.action == lc3_pkg::ACT_STEP && !stat.halted) begin
          state_next = lc3_pkg::S_DEC;
        end else begin
          state_next = lc3_pkg::S_OUT;
        end
      end
      lc3_pkg::S_RDONE: state_next = lc3_pkg::S_OUT;
      lc3_pkg::S_DEC:   state_next = lc3_pkg::S_EXEC;
      lc3_pkg::S_EXEC: begin
        if (stat.need_ind) begin
          state_next = lc3_pkg::S_IND;
        end else if (stat.need_sti) begin
          state_next = lc3_pkg::S_STI;
        end else if (stat.need_wb) begin
          state_next = lc3_pkg::S_WB;
        end else begin
          state_next = lc3_pkg::S_OUT;
        end
      end
      lc3_pkg::S_IND: state_next = lc3_pkg::S_WB;
      lc3_pkg::S_STI: state_next = lc3_pkg::S_OUT;
      lc3_pkg::S_WB:  state_next = lc3_pkg::S_OUT;
      lc3_pkg::S_OUT: begin
        if (!out_stall) state_next = lc3_pkg::S_IDLE;
      end
      default: state_next = lc3_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lc3_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall  = (state != lc3_pkg::S_IDLE);
  assign out_valid = (state == lc3_pkg::S_OUT);
  assign cmd.load  = (state == lc3_pkg::S_IDLE) && in_valid;
  assign cmd.step  = state;

endmodule

### hw/rtl/lc3_dp.sv
// Datapath of the LC-3 core: word memory, register file, PC, flags and the
// result registers. Driven by lc3_ctrl commands; depends on lc3_pkg.
module lc3_dp #(
  parameter int MEM_WORDS = 65536
) (
  input  logic                clk,
  input  logic                rst,
  input  lc3_pkg::cmd_t       cmd,
  output lc3_pkg::stat_t      stat,
  input  lc3_pkg::in_item_t   in_item,
  output lc3_pkg::out_item_t  out_item,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [AW-1:0] LAST = AW'(MEM_WORDS - 1);

  logic [15:0] mem [MEM_WORDS];
  logic [15:0] mem_q;
  logic        rd_ok;
  logic [15:0] rdata;
  logic [15:0] mem_addr;
  logic [15:0] mem_wd;
  logic        mem_we;
  logic        mem_in_range;
  logic [AW-1:0] clr_cnt;

  logic [15:0] rf [8];
  logic [15:0] ra_q;
  logic [15:0] rb_q;
  logic [2:0]  ra_addr;
  logic [2:0]  rb_addr;
  logic        rf_we;
  logic [2:0]  rf_wa;
  logic [15:0] rf_wd;

  lc3_pkg::in_item_t item;
  logic [15:0] start_pc;
  logic [15:0] pc;
  logic [15:0] pc_next;
  logic [2:0]  flags;
  logic [2:0]  flags_next;
  logic        halted;
  logic        halted_next;
  logic [15:0] ins;
  logic [2:0]  ev;
  logic [2:0]  ev_next;
  logic [7:0]  ch;
  logic [7:0]  ch_next;
  logic [15:0] dat;
  logic [15:0] dat_next;

  logic [3:0]  op;
  logic [2:0]  dr;
  logic [15:0] off9;
  logic [15:0] off6;
  logic [15:0] off11;
  logic [15:0] imm5;
  logic [15:0] alu;
  logic [3:0]  dec_op;

  assign rdata        = rd_ok ? mem_q : 16'd0;
  assign mem_in_range = ({1'b0, mem_addr} < 17'(MEM_WORDS));

  assign op    = ins[15:12];
  assign dr    = ins[11:9];
  assign off9  = {{7{ins[8]}}, ins[8:0]};
  assign off6  = {{10{ins[5]}}, ins[5:0]};
  assign off11 = {{5{ins[10]}}, ins[10:0]};
  assign imm5  = {{11{ins[4]}}, ins[4:0]};

  // Register read addresses come from the word just fetched.
  assign dec_op  = rdata[15:12];
  assign ra_addr = (dec_op == lc3_pkg::OP_TRAP) ? 3'd0 : rdata[8:6];
  assign rb_addr = (dec_op == lc3_pkg::OP_ST || dec_op == lc3_pkg::OP_STR ||
                    dec_op == lc3_pkg::OP_STI) ? rdata[11:9] : rdata[2:0];

  always_comb begin
    mem_addr    = item.address;
    mem_wd      = item.data;
    mem_we      = 1'b0;
    rf_we       = 1'b0;
    rf_wa       = dr;
    rf_wd       = 16'd0;
    pc_next     = pc;
    flags_next  = flags;
    halted_next = halted;
    ev_next     = ev;
    ch_next     = ch;
    dat_next    = dat;
    alu         = 16'd0;
    if (cmd.load) begin
      ev_next  = lc3_pkg::EV_NONE;
      ch_next  = 8'd0;
      dat_next = 16'd0;
    end
    case (cmd.step)
      lc3_pkg::S_CLEAR: begin
        mem_addr = 16'(clr_cnt);
        mem_wd   = 16'd0;
        mem_we   = 1'b1;
      end
      lc3_pkg::S_ISSUE: begin
        case (item.action)
          lc3_pkg::ACT_WRITE: mem_we = mem_in_range;
          lc3_pkg::ACT_READ:  mem_we = 1'b0;
          lc3_pkg::ACT_STEP: begin
            mem_addr = pc;
            if (halted) ev_next = lc3_pkg::EV_STOPPED;
          end
          default: begin
            pc_next     = start_pc;
            halted_next = 1'b0;
          end
        endcase
      end
      lc3_pkg::S_RDONE: dat_next = rdata;
      lc3_pkg::S_DEC:   pc_next = pc + 16'd1;
      lc3_pkg::S_EXEC: begin
        case (op)
          lc3_pkg::OP_BR: begin
            if ((dr & flags) != 3'd0) pc_next = pc + off9;
          end
          lc3_pkg::OP_ADD, lc3_pkg::OP_AND: begin
            if (op == lc3_pkg::OP_ADD) begin
              alu = ra_q + (ins[5] ? imm5 : rb_q);
            end else begin
              alu = ra_q & (ins[5] ? imm5 : rb_q);
            end
            rf_we      = 1'b1;
            rf_wd      = alu;
            flags_next = lc3_pkg::flags_of(alu);
          end
          lc3_pkg::OP_LD, lc3_pkg::OP_LDI, lc3_pkg::OP_STI: begin
            mem_addr = pc + off9;
          end
          lc3_pkg::OP_ST: begin
            mem_addr = pc + off9;
            mem_wd   = rb_q;
            mem_we   = mem_in_range;
          end
          lc3_pkg::OP_JSR: begin
            rf_we   = 1'b1;
            rf_wa   = 3'd7;
            rf_wd   = pc;
            pc_next = ins[11] ? pc + off11 : ra_q;
          end
          lc3_pkg::OP_LDR: mem_addr = ra_q + off6;
          lc3_pkg::OP_STR: begin
            mem_addr = ra_q + off6;
            mem_wd   = rb_q;
            mem_we   = mem_in_range;
          end
          lc3_pkg::OP_NOT: begin
            rf_we      = 1'b1;
            rf_wd      = ~ra_q;
            flags_next = lc3_pkg::flags_of(~ra_q);
          end
          lc3_pkg::OP_JMP: pc_next = ra_q;
          lc3_pkg::OP_LEA: begin
            rf_we      = 1'b1;
            rf_wd      = pc + off9;
            flags_next = lc3_pkg::flags_of(pc + off9);
          end
          lc3_pkg::OP_TRAP: begin
            rf_we = 1'b1;
            rf_wa = 3'd7;
            rf_wd = pc;
            case (ins[7:0])
              lc3_pkg::TV_OUT: begin
                ev_next = lc3_pkg::EV_CHAR;
                ch_next = ra_q[7:0];
              end
              lc3_pkg::TV_PUTS, lc3_pkg::TV_PUTSP: begin
                ev_next  = lc3_pkg::EV_STRING;
                dat_next = ra_q;
              end
              lc3_pkg::TV_IN: begin
                ev_next = lc3_pkg::EV_CHAR;
                ch_next = item.key;
              end
              lc3_pkg::TV_HALT: begin
                ev_next     = lc3_pkg::EV_HALT;
                halted_next = 1'b1;
              end
              default: ev_next = ev;
            endcase
          end
          default: begin
            ev_next     = lc3_pkg::EV_ILLEGAL;
            halted_next = 1'b1;
          end
        endcase
      end
      lc3_pkg::S_IND: mem_addr = rdata;
      lc3_pkg::S_STI: begin
        mem_addr = rdata;
        mem_wd   = rb_q;
        mem_we   = mem_in_range;
      end
      lc3_pkg::S_WB: begin
        rf_we = 1'b1;
        if (op == lc3_pkg::OP_TRAP) begin
          rf_wa = 3'd0;
          rf_wd = {8'd0, item.key};
        end else begin
          rf_wd = rdata;
        end
        flags_next = lc3_pkg::flags_of(rf_wd);
      end
      default: mem_we = 1'b0;
    endcase
  end

  // Word memory with one port and a registered read.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr[AW-1:0]] <= mem_wd;
    mem_q <= mem[mem_addr[AW-1:0]];
    rd_ok <= mem_in_range;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) rf[i] <= 16'd0;
    end else if (rf_we) begin
      rf[rf_wa] <= rf_wd;
    end
    if (cmd.step == lc3_pkg::S_DEC) begin
      ins  <= rdata;
      ra_q <= rf[ra_addr];
      rb_q <= rf[rb_addr];
    end
    if (cmd.load) item <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      start_pc <= lc3_pkg::START_PC_RESET;
      pc       <= lc3_pkg::START_PC_RESET;
      flags    <= lc3_pkg::FLAG_Z;
      halted   <= 1'b0;
      ev       <= lc3_pkg::EV_NONE;
      ch       <= 8'd0;
      dat      <= 16'd0;
    end else begin
      if (cmd.step == lc3_pkg::S_CLEAR) clr_cnt <= clr_cnt + AW'(1);
      if (cfg_we) start_pc <= cfg_data;
      pc     <= pc_next;
      flags  <= flags_next;
      halted <= halted_next;
      ev     <= ev_next;
      ch     <= ch_next;
      dat    <= dat_next;
    end
  end

  assign stat.clear_done = (clr_cnt == LAST);
  assign stat.action     = item.action;
  assign stat.halted     = halted;
  assign stat.need_ind   = (op == lc3_pkg::OP_LDI);
  assign stat.need_sti   = (op == lc3_pkg::OP_STI);
  assign stat.need_wb    = (op == lc3_pkg::OP_LD) || (op == lc3_pkg::OP_LDR) ||
                           (op == lc3_pkg::OP_TRAP &&
                            (ins[7:0] == lc3_pkg::TV_GETC ||
                             ins[7:0] == lc3_pkg::TV_IN));

  assign out_item.event_res = ev;
  assign out_item.pc_now    = pc;
  assign out_item.char_out  = ch;
  assign out_item.data_out  = dat;
  assign out_item.flags     = flags;
  assign out_item.stopped   = halted;

endmodule

### hw/rtl/lc3_instruction_core_unit.sv
// Top level of the LC-3 instruction core: controller plus datapath.
// Depends on lc3_pkg, lc3_ctrl and lc3_dp.
//
// This block is a 16-bit LC-3 core with its own word memory of MEM_WORDS
// words. Each input transfer carries one action: write a memory word, read a
// memory word, step one instruction, or restart at start_pc; each produces
// exactly one result transfer. One item is handled at a time. A write,
// restart or step while stopped goes from issue straight to the result, a
// read adds a read-done state, and any other step adds decode and execute;
// LD, LDR and the GETC and IN traps then add a write-back, LDI an indirect
// read and a write-back, and STI an indirect store. These states come from the
// single memory port with a registered read, which serves fetch, loads and
// stores in turn, and from the registered register file reads. After reset the
// memory is cleared one word per cycle and no input is taken until it is done;
// start_pc writes are accepted at all times and move the PC only on restart.
module lc3_instruction_core_unit #(
  parameter int MEM_WORDS = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  lc3_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output lc3_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  lc3_pkg::cmd_t  cmd;
  lc3_pkg::stat_t stat;

  // The start_pc register can always take a transfer.
  assign cfg_ready = 1'b1;

  lc3_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  lc3_dp #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_item  (in_item),
    .out_item (out_item),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data)
  );

endmodule
